// File: src/rbrf_pkg.sv
// ----------------------------------------------------------------------------
// rbrf_pkg
// Shared constants, types and helpers of the rotating blob ring renderer.
// ----------------------------------------------------------------------------
package rbrf_pkg;

  localparam int LED_COUNT = 24;
  localparam int LED_W     = 6;
  localparam int IDX_W     = $clog2(LED_COUNT);
  localparam int FRAC_W    = 15;
  localparam int POS_W     = 21;
  localparam int UNIT      = 1 << FRAC_W;
  localparam int SPAN      = LED_COUNT * UNIT;
  localparam int HALF      = LED_COUNT * (UNIT / 2);
  localparam int CB_W      = 16;
  localparam int S_W       = 26;
  localparam int P_W       = CB_W + S_W;
  localparam int X_W       = 30;

  localparam logic       OP_RENDER  = 1'b0;
  localparam logic       OP_RESTART = 1'b1;

  localparam logic [2:0] REG_SPEED = 3'd0;
  localparam logic [2:0] REG_TRAIL = 3'd4;

  typedef struct packed {
    logic [CB_W-1:0]   cb_r;
    logic [CB_W-1:0]   cb_g;
    logic [CB_W-1:0]   cb_b;
    logic [CB_W-1:0]   cb_m;
    logic [7:0]        q_r;
    logic [7:0]        q_g;
    logic [7:0]        q_b;
    logic [IDX_W-1:0]  h0;
    logic [IDX_W-1:0]  h1;
    logic [FRAC_W-1:0] f0;
    logic [FRAC_W-1:0] f1;
    logic [1:0]        n;
  } frame_t;

  function automatic logic [8:0] elem_weight(input logic [1:0] k);
    logic [8:0] w;
    case (k)
      2'd0:    w = 9'd256;
      2'd1:    w = 9'd136;
      2'd2:    w = 9'd56;
      default: w = 9'd12;
    endcase
    return w;
  endfunction

endpackage

// File: src/rbrf_cmd_if.sv
// ----------------------------------------------------------------------------
// rbrf_cmd_if
// Command channel: render or restart requests with color and timing.
// ----------------------------------------------------------------------------
interface rbrf_cmd_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] frame_time;
  logic [7:0]  base_red;
  logic [7:0]  base_green;
  logic [7:0]  base_blue;
  logic [7:0]  brightness;

  modport source (output valid, op, frame_time, base_red, base_green, base_blue,
                  brightness, input ready);
  modport sink (input valid, op, frame_time, base_red, base_green, base_blue,
                brightness, output ready);
endinterface

// File: src/rbrf_led_if.sv
// ----------------------------------------------------------------------------
// rbrf_led_if
// LED channel: one color transaction per ring LED.
// ----------------------------------------------------------------------------
interface rbrf_led_if;
  logic       valid;
  logic       ready;
  logic [5:0] led_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       last;

  modport source (output valid, led_index, red, green, blue, last, input ready);
  modport sink (input valid, led_index, red, green, blue, last, output ready);
endinterface

// File: src/rbrf_front.sv
// ----------------------------------------------------------------------------
// rbrf_front
// Accepts commands, keeps the ring position and prepares one frame job.
// ----------------------------------------------------------------------------
module rbrf_front (
  input  logic                 clk,
  input  logic                 rst,
  rbrf_cmd_if.sink             cmd,
  input  logic [15:0]          speed,
  input  logic [3:0]           trail_length,
  output logic                 push_valid,
  input  logic                 push_ready,
  output rbrf_pkg::frame_t     push_frame
);
  import rbrf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CALC = 3'b010,
    S_PUSH = 3'b100
  } state_t;

  localparam logic [X_W-1:0] SPAN_X = X_W'(SPAN);
  localparam logic [X_W-1:0] BIAS   = X_W'(SPAN * 128);

  state_t           state;
  logic [2:0]       step;
  logic [POS_W-1:0] pos;
  logic [X_W-1:0]   x;
  logic [15:0]      rem_r, rem_g, rem_b;
  logic [8:0]       dm;
  frame_t           frame;

  logic             accept;
  logic [7:0]       mx;
  logic [POS_W:0]   c1_sum;
  logic [POS_W-1:0] c1;
  logic signed [32:0] prod;
  logic [23:0]      delta;
  logic [X_W-1:0]   span_sh;
  logic [16:0]      dm_sh;

  assign cmd.ready  = (state == S_IDLE);
  assign accept     = cmd.valid && cmd.ready;
  assign push_valid = (state == S_PUSH);
  assign push_frame = frame;

  always_comb begin
    mx = cmd.base_red;
    if (cmd.base_green > mx) mx = cmd.base_green;
    if (cmd.base_blue > mx) mx = cmd.base_blue;
    c1_sum = {1'b0, pos} + (POS_W + 1)'(HALF);
    if (c1_sum >= (POS_W + 1)'(SPAN)) begin
      c1_sum = c1_sum - (POS_W + 1)'(SPAN);
    end
    c1 = c1_sum[POS_W-1:0];
    prod = $signed(speed) * $signed({1'b0, cmd.frame_time});
    delta = prod[32:9];
    span_sh = SPAN_X << step;
    dm_sh = {8'd0, dm} << step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= 3'd0;
      pos   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (cmd.op == OP_RESTART) begin
              pos <= '0;
            end else begin
              state <= S_CALC;
              step  <= 3'd7;
            end
          end
        end
        S_CALC: begin
          if (step == 3'd0) begin
            state <= S_PUSH;
          end
          step <= step - 3'd1;
        end
        S_PUSH: begin
          if (push_ready) begin
            pos   <= x[POS_W-1:0];
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) begin
      frame.cb_r <= cmd.base_red * cmd.brightness;
      frame.cb_g <= cmd.base_green * cmd.brightness;
      frame.cb_b <= cmd.base_blue * cmd.brightness;
      frame.cb_m <= mx * cmd.brightness;
      frame.q_r  <= '0;
      frame.q_g  <= '0;
      frame.q_b  <= '0;
      frame.h0   <= IDX_W'(pos >> FRAC_W);
      frame.f0   <= pos[FRAC_W-1:0];
      frame.h1   <= IDX_W'(c1 >> FRAC_W);
      frame.f1   <= c1[FRAC_W-1:0];
      frame.n    <= (trail_length > 4'd3) ? 2'd3 : trail_length[1:0];
      rem_r      <= {cmd.base_red, mx};
      rem_g      <= {cmd.base_green, mx};
      rem_b      <= {cmd.base_blue, mx};
      dm         <= {mx, 1'b0};
      x          <= X_W'(pos) + BIAS + {{(X_W - 24){delta[23]}}, delta};
    end else if (state == S_CALC) begin
      if (x >= span_sh) x <= x - span_sh;
      if ({1'b0, rem_r} >= dm_sh) begin
        rem_r <= rem_r - dm_sh[15:0];
        frame.q_r[step] <= 1'b1;
      end
      if ({1'b0, rem_g} >= dm_sh) begin
        rem_g <= rem_g - dm_sh[15:0];
        frame.q_g[step] <= 1'b1;
      end
      if ({1'b0, rem_b} >= dm_sh) begin
        rem_b <= rem_b - dm_sh[15:0];
        frame.q_b[step] <= 1'b1;
      end
    end
  end

endmodule

// File: src/rbrf_queue.sv
// ----------------------------------------------------------------------------
// rbrf_queue
// Two-entry queue of frame jobs between the front and the back.
// ----------------------------------------------------------------------------
module rbrf_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  rbrf_pkg::frame_t push_frame,
  output logic             pop_valid,
  input  logic             pop_ready,
  output rbrf_pkg::frame_t pop_frame
);
  import rbrf_pkg::*;

  frame_t     mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_frame  = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_frame;
  end

endmodule

// File: src/rbrf_back.sv
// ----------------------------------------------------------------------------
// rbrf_back
// Walks the ring for one frame job and emits one color per LED through a
// three-stage pipeline: blob weights, channel products, scaling.
// ----------------------------------------------------------------------------
module rbrf_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  rbrf_pkg::frame_t pop_frame,
  rbrf_led_if.source       led
);
  import rbrf_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(LED_COUNT - 1);
  localparam logic [P_W-1:0]   DIM_LIMIT = P_W'(128 * 255) << 23;

  logic             en;
  logic [IDX_W-1:0] idx;

  logic             s1_valid, s1_mic, s1_last;
  logic [IDX_W-1:0] s1_idx;
  logic [S_W-1:0]   s1_sum;
  frame_t           s1_frame;

  logic             s2_valid, s2_mic, s2_last;
  logic [IDX_W-1:0] s2_idx;
  logic [P_W-1:0]   s2_pr, s2_pg, s2_pb, s2_pm;
  logic [7:0]       s2_qr, s2_qg, s2_qb;

  logic [S_W-1:0]   sum;
  logic [LED_W-1:0] idx_ext;
  logic             mic;
  logic             dim;

  function automatic logic [S_W-1:0] blob_sum(input logic [IDX_W-1:0] h,
                                               input logic [FRAC_W-1:0] f,
                                               input logic [1:0] n,
                                               input logic [IDX_W-1:0] i);
    logic [IDX_W:0]   diff;
    logic [IDX_W-1:0] d;
    logic [IDX_W-1:0] kn;
    logic [16:0]      uf;
    logic [S_W-1:0]   acc;
    diff = {1'b0, h} - {1'b0, i};
    if (diff[IDX_W]) diff = diff + (IDX_W + 1)'(LED_COUNT);
    d   = diff[IDX_W-1:0];
    uf  = 17'(UNIT) - {2'b00, f};
    acc = '0;
    for (int k = 0; k < 4; k++) begin
      kn = (k == 0) ? IDX_W'(LED_COUNT - 1) : IDX_W'(k - 1);
      if (2'(k) <= n) begin
        if (d == IDX_W'(k)) begin
          acc = acc + S_W'(elem_weight(2'(k))) * S_W'(uf);
        end
        if (d == kn) begin
          acc = acc + S_W'(elem_weight(2'(k))) * S_W'(f);
        end
      end
    end
    return acc;
  endfunction

  function automatic logic [7:0] scale255(input logic [P_W-1:0] p);
    logic [P_W:0] t;
    logic [19:0]  y;
    logic [7:0]   q;
    logic [8:0]   r;
    t = {1'b0, p} + ((P_W + 1)'(255) << 22);
    y = t[P_W:23];
    q = y[15:8];
    r = {1'b0, y[7:0]} + {1'b0, q};
    if (r >= 9'd255) q = q + 8'd1;
    if (y >= 20'd65025) q = 8'd255;
    return q;
  endfunction

  assign en        = !led.valid || led.ready;
  assign pop_ready = en && (idx == LAST_IDX);
  assign idx_ext   = LED_W'(idx);
  assign mic       = (idx_ext == 6'd0) || (idx_ext == 6'd6) || (idx_ext == 6'd12) ||
                     (idx_ext == 6'd18);
  assign sum       = blob_sum(pop_frame.h0, pop_frame.f0, pop_frame.n, idx) +
                     blob_sum(pop_frame.h1, pop_frame.f1, pop_frame.n, idx);
  assign dim       = s2_mic && (s2_pm > DIM_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      led.valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= pop_valid;
      s2_valid  <= s1_valid;
      led.valid <= s2_valid;
      if (pop_valid) begin
        idx <= (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sum   <= sum;
      s1_mic   <= mic;
      s1_last  <= (idx == LAST_IDX);
      s1_idx   <= idx;
      s1_frame <= pop_frame;

      s2_pr   <= s1_frame.cb_r * s1_sum;
      s2_pg   <= s1_frame.cb_g * s1_sum;
      s2_pb   <= s1_frame.cb_b * s1_sum;
      s2_pm   <= s1_frame.cb_m * s1_sum;
      s2_qr   <= s1_frame.q_r;
      s2_qg   <= s1_frame.q_g;
      s2_qb   <= s1_frame.q_b;
      s2_mic  <= s1_mic;
      s2_last <= s1_last;
      s2_idx  <= s1_idx;

      led.led_index <= LED_W'(s2_idx);
      led.last      <= s2_last;
      led.red       <= dim ? s2_qr : scale255(s2_pr);
      led.green     <= dim ? s2_qg : scale255(s2_pg);
      led.blue      <= dim ? s2_qb : scale255(s2_pb);
    end
  end

endmodule

// File: src/rotating_blob_ring_frame.sv
// ----------------------------------------------------------------------------
// rotating_blob_ring_frame
// Renders two opposite rotating blobs with trails onto an LED ring.
// ----------------------------------------------------------------------------
// A render transaction produces one color transaction per LED, LED 0 first,
// with last set on the final LED. The front takes a render command and then
// runs an eight-step shared loop that reduces the new position modulo the
// ring and divides out the dimming ratios; a restart clears the position and
// produces nothing. The back emits one LED per cycle while led.ready does not
// stall it, through its blob weight, channel product and scaling stages, and
// the LED counter in the back sets the sustained rate. A two-entry job queue
// lets the front prepare the next frame while the back is still emitting.
module rotating_blob_ring_frame (
  input  logic        clk,
  input  logic        rst,
  rbrf_cmd_if.sink    cmd,
  rbrf_led_if.source  led,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rbrf_pkg::*;

  logic [15:0] speed;
  logic [3:0]  trail_length;
  logic        push_valid, push_ready;
  frame_t      push_frame;
  logic        pop_valid, pop_ready;
  frame_t      pop_frame;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed        <= 16'd256;
      trail_length <= 4'd2;
    end else if (wr_en) begin
      unique case ({paddr[2], 2'b00})
        REG_SPEED: speed        <= pwdata[15:0];
        REG_TRAIL: trail_length <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case ({paddr[2], 2'b00})
      REG_SPEED: prdata = {16'd0, speed};
      REG_TRAIL: prdata = {28'd0, trail_length};
      default:   prdata = '0;
    endcase
  end

  rbrf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .speed        (speed),
    .trail_length (trail_length),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_frame   (push_frame)
  );

  rbrf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_frame (push_frame),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_frame  (pop_frame)
  );

  rbrf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_frame (pop_frame),
    .led       (led)
  );

endmodule

// File: src/rbrf_checker.sv
// ----------------------------------------------------------------------------
// rbrf_checker
// Port-level checks of the LED output of the ring renderer.
// ----------------------------------------------------------------------------
module rbrf_checker (
  input logic       clk,
  input logic       rst,
  input logic       led_valid,
  input logic       led_ready,
  input logic [5:0] led_index,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue,
  input logic       last
);
  import rbrf_pkg::*;

  logic mic;
  assign mic = (led_index == 6'd0) || (led_index == 6'd6) || (led_index == 6'd12) ||
               (led_index == 6'd18);

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    led_valid |-> (led_index < LED_W'(LED_COUNT)))
    else $error("LED index beyond the ring");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    led_valid |-> (last == (led_index == LED_W'(LED_COUNT - 1))))
    else $error("last flag does not match the final LED");

  a_mic_dimmed: assert property (@(posedge clk) disable iff (rst)
    (led_valid && mic) |-> (red <= 8'd128 && green <= 8'd128 && blue <= 8'd128))
    else $error("dimmed LED exceeds its channel limit");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (led_valid && !led_ready) |=> (led_valid && $stable(led_index) && $stable(red)))
    else $error("stalled LED transaction changed");

endmodule

bind rotating_blob_ring_frame rbrf_checker u_rbrf_checker (
  .clk       (clk),
  .rst       (rst),
  .led_valid (led.valid),
  .led_ready (led.ready),
  .led_index (led.led_index),
  .red       (led.red),
  .green     (led.green),
  .blue      (led.blue),
  .last      (led.last)
);
